FILE: hw/rtl/epf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased PWM fade package
// Shared widths, codes, payload structs and controller command/status types.
// ----------------------------------------------------------------------------
package epf_pkg;

   // Fixed field widths.
   localparam int LEVEL_W   = 10;
   localparam int TIME_W    = 32;
   localparam int DUR_W     = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = DUR_W;

   // Default fraction width of the fade position.
   localparam int FRAC_BITS_DEFAULT = 16;

   // Full-scale level and register reset values.
   localparam logic [LEVEL_W-1:0] PWM_MAX = 10'd1023;
   localparam logic [DUR_W-1:0]   DURATION_RESET = 16'd1000;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_DURATION = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_OUTPUT = 1'b1;

   // Request mode codes.
   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_SET  = 1'b1
   } mode_type;

   // Request and result payloads.
   typedef struct packed {
      mode_type               mode;
      logic [LEVEL_W-1:0]     target_level;
      logic [TIME_W-1:0]      time_ms;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]     duty;
      logic [LEVEL_W-1:0]     level;
      logic                   fade_done;
   } rsp_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE,
      ST_SQUARE,
      ST_SCALE,
      ST_UPDATE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic set_load;
      logic tick_load;
      logic div_init;
      logic div_step;
      logic square;
      logic scale;
      logic update;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fade_active;
      logic rsp_busy;
   } status_type;

endpackage

FILE: hw/rtl/epf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased PWM fade controller
// Sequences one request at a time; a tick during a fade runs through the
// load, divide, square, scale and update steps of the datapath.
// ----------------------------------------------------------------------------
module epf_ctrl #(
   parameter int FRAC_BITS = epf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  epf_pkg::mode_type    req_mode,
   output logic                 req_ready,
   input  epf_pkg::status_type  status,
   output epf_pkg::cmd_type     cmd
);
   import epf_pkg::*;

   localparam int CNT_W = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept && req_mode == MODE_SET) begin
               cmd.set_load = 1'b1;
            end else if (accept && status.fade_active) begin
               cmd.tick_load = 1'b1;
               state_in      = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.div_init = 1'b1;
            cnt_in       = CNT_LAST;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            // Hold until the result register can take a new result.
            if (!status.rsp_busy) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/epf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased PWM fade datapath
// Fade state, configuration registers, a restoring divider for the fade
// position, a square step for the easing curve, a scale step for the level
// difference and the result register.
module epf_datapath #(
   parameter int FRAC_BITS = epf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  epf_pkg::req_type               req_payload,
   input  epf_pkg::cmd_type               cmd,
   output epf_pkg::status_type            status,
   input  logic                           csr_wen,
   input  logic [epf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [epf_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output epf_pkg::rsp_type               rsp_payload
);
   import epf_pkg::*;

   localparam int T_W    = FRAC_BITS + 1;
   localparam int TWO_W  = FRAC_BITS + 2;
   localparam int SQ_W   = 2 * FRAC_BITS + 3;
   localparam int MAG_W  = FRAC_BITS + LEVEL_W + 2;
   localparam logic [T_W-1:0]   Q_ONE   = T_W'(1) << FRAC_BITS;
   localparam logic [TWO_W-1:0] Q_TWO   = TWO_W'(1) << (FRAC_BITS + 1);
   localparam logic [MAG_W-1:0] Q_ROUND = (MAG_W'(1) << FRAC_BITS) - MAG_W'(1);

   // Configuration and fade state.
   logic [DUR_W-1:0]     dur_ff, dur_in;
   logic                 invert_ff, invert_in;
   logic [LEVEL_W-1:0]   cur_level_ff, cur_level_in;
   logic [LEVEL_W-1:0]   start_level_ff, start_level_in;
   logic [LEVEL_W-1:0]   dest_level_ff, dest_level_in;
   logic [TIME_W-1:0]    start_time_ff, start_time_in;
   logic                 active_ff, active_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Working registers of one tick.
   logic [TIME_W-1:0]    elapsed_ff, elapsed_in;
   logic                 t_sat_ff, t_sat_in;
   logic                 down_ff, down_in;
   logic [LEVEL_W-1:0]   diff_ff, diff_in;
   logic [DUR_W-1:0]     rem_ff, rem_in;
   logic [FRAC_BITS-1:0] quot_ff, quot_in;
   logic [T_W-1:0]       ease_ff, ease_in;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   rsp_type              rsp_ff, rsp_in;

   // Combinational helpers.
   logic [LEVEL_W-1:0]   target_sat;
   logic [DUR_W:0]       rem_shift;
   logic [DUR_W:0]       rem_sub;
   logic [T_W-1:0]       t_pos;
   logic [TWO_W-1:0]     two_minus_t;
   logic [SQ_W-1:0]      sq_prod;
   logic [MAG_W-1:0]     mag_round;
   logic [LEVEL_W-1:0]   step;
   logic [LEVEL_W-1:0]   val;

   // Control registers with reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         dur_ff         <= DURATION_RESET;
         invert_ff      <= 1'b0;
         cur_level_ff   <= '0;
         start_level_ff <= '0;
         dest_level_ff  <= '0;
         start_time_ff  <= '0;
         active_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         dur_ff         <= dur_in;
         invert_ff      <= invert_in;
         cur_level_ff   <= cur_level_in;
         start_level_ff <= start_level_in;
         dest_level_ff  <= dest_level_in;
         start_time_ff  <= start_time_in;
         active_ff      <= active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      elapsed_ff <= elapsed_in;
      t_sat_ff   <= t_sat_in;
      down_ff    <= down_in;
      diff_ff    <= diff_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      ease_ff    <= ease_in;
      mag_ff     <= mag_in;
      rsp_ff     <= rsp_in;
   end

   // Arithmetic of the individual steps.
   always_comb begin
      target_sat  = (req_payload.target_level > PWM_MAX) ? PWM_MAX
                                                         : req_payload.target_level;
      rem_shift   = {rem_ff, 1'b0};
      rem_sub     = rem_shift - {1'b0, dur_ff};
      t_pos       = t_sat_ff ? Q_ONE : {1'b0, quot_ff};
      two_minus_t = Q_TWO - TWO_W'(t_pos);
      sq_prod     = SQ_W'(t_pos) * SQ_W'(two_minus_t);
      // Rising fades round the step up, falling fades round it down.
      mag_round   = down_ff ? mag_ff : mag_ff + Q_ROUND;
      step        = mag_round[FRAC_BITS +: LEVEL_W];
      val         = down_ff ? start_level_ff - step : start_level_ff + step;
   end

   // Next values of all registers.
   always_comb begin
      dur_in         = dur_ff;
      invert_in      = invert_ff;
      cur_level_in   = cur_level_ff;
      start_level_in = start_level_ff;
      dest_level_in  = dest_level_ff;
      start_time_in  = start_time_ff;
      active_in      = active_ff;
      rsp_valid_in   = rsp_valid_ff;
      elapsed_in     = elapsed_ff;
      t_sat_in       = t_sat_ff;
      down_in        = down_ff;
      diff_in        = diff_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      ease_in        = ease_ff;
      mag_in         = mag_ff;
      rsp_in         = rsp_ff;

      // Configuration writes.
      if (csr_wen) begin
         case (csr_index)
            CSR_FADE_DURATION: dur_in    = csr_wdata;
            CSR_INVERT_OUTPUT: invert_in = csr_wdata[0];
            default: begin
            end
         endcase
      end

      // A set request restarts the fade from the present level.
      if (cmd.set_load) begin
         start_level_in = cur_level_ff;
         dest_level_in  = target_sat;
         start_time_in  = req_payload.time_ms;
         active_in      = 1'b1;
      end

      // A tick request captures the elapsed time, modulo the time stamp width.
      if (cmd.tick_load) begin
         elapsed_in = req_payload.time_ms - start_time_ff;
      end

      // Saturate the fade position or prepare the divider.
      if (cmd.div_init) begin
         t_sat_in = (dur_ff == '0) || (elapsed_ff >= TIME_W'(dur_ff));
         rem_in   = elapsed_ff[DUR_W-1:0];
         quot_in  = '0;
         down_in  = dest_level_ff < start_level_ff;
         diff_in  = (dest_level_ff < start_level_ff) ? start_level_ff - dest_level_ff
                                                     : dest_level_ff - start_level_ff;
      end

      // One quotient bit of elapsed * 2^FRAC_BITS / duration per cycle.
      if (cmd.div_step) begin
         if (!rem_sub[DUR_W]) begin
            rem_in  = rem_sub[DUR_W-1:0];
            quot_in = {quot_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[DUR_W-1:0];
            quot_in = {quot_ff[FRAC_BITS-2:0], 1'b0};
         end
      end

      // Ease-out curve t * (2 - t).
      if (cmd.square) begin
         ease_in = sq_prod[FRAC_BITS +: T_W];
      end

      // Scale the level difference by the eased position.
      if (cmd.scale) begin
         mag_in = MAG_W'(ease_ff) * MAG_W'(diff_ff);
      end

      // Drain the result register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Commit the new level and load the result register.
      if (cmd.update) begin
         cur_level_in     = val;
         active_in        = (val != dest_level_ff);
         rsp_valid_in     = 1'b1;
         rsp_in.level     = val;
         rsp_in.duty      = invert_ff ? PWM_MAX - val : val;
         rsp_in.fade_done = (val == dest_level_ff);
      end
   end

   assign status.fade_active = active_ff;
   assign status.rsp_busy    = rsp_valid_ff && !rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_ff;

endmodule

FILE: hw/rtl/eased_pwm_fade_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Eased PWM fade core
// Fades a PWM level toward a target along an ease-out-quadratic curve.
// ----------------------------------------------------------------------------
// A set request (mode 1) produces no result; it starts a new fade from the
// present level toward target_level at time_ms. A tick request (mode 0)
// while a fade runs produces one result and occupies the core until that
// result is loaded into the result register; a tick with no fade running
// produces nothing. A tick passes through the steps of loading the
// operands, the restoring divider that forms the fade position one quotient
// bit per cycle, the square and the scale multiplications and the update.
// One request is handled at a time; a new request is taken while the last
// result still waits in the result register, and a tick whose result is
// ready while the previous one still waits holds in its update step until
// that result is taken. The user must write fade_duration_ms and
// invert_output through the csr_ port only while the core is idle; the
// core itself does not enforce it.
// ----------------------------------------------------------------------------
module eased_pwm_fade_core #(
   parameter int FRAC_BITS = epf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  epf_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output epf_pkg::rsp_type               rsp_payload,
   input  logic                           csr_wen,
   input  logic [epf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [epf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import epf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Request sequencing.
   epf_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_payload.mode),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Fade arithmetic and state.
   epf_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
